// ----- sv/lsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lsfr_pkg
// shared types, codes and helpers of the lin slave frame receiver
// ----------------------------------------------------------------------------
package lsfr_pkg;

  localparam int MAX_DATA_BYTES_DEF = 8;

  localparam logic [63:0] RESP_MASK_RST = 64'h0020_0004_0000_0008;
  localparam logic [63:0] RECV_MASK_RST = 64'h0010_0002_0000_0010;
  localparam logic [3:0]  DATA_LEN_RST  = 4'd8;

  localparam logic [7:0] BREAK_BYTE = 8'h00;
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [5:0] ID_DIAG_REQ = 6'h3C;
  localparam logic [5:0] ID_DIAG_RSP = 6'h3D;

  typedef enum logic [1:0] {
    CFG_RESP_MASK = 2'd0,
    CFG_RECV_MASK = 2'd1,
    CFG_DATA_LEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_RESP = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_SYNC = 6'b000010,
    PH_PID  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CSUM = 6'b010000,
    PH_RESP = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] frame_id;
    logic [7:0] data_byte;
    logic [2:0] byte_index;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic       last;
  } res_t;

  // protected id check: both parity bits must match the id bits
  function automatic logic pid_ok(input logic [7:0] pid);
    logic p0;
    logic p1;
    p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
    p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
    return (pid[6] == p0) && (pid[7] == p1);
  endfunction

endpackage

// ----- sv/lsfr_core.sv -----
// ----------------------------------------------------------------------------
// lsfr_core
// frame state machine, config registers and checksum accumulation
// ----------------------------------------------------------------------------
module lsfr_core
  import lsfr_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_wr_t    cfg_wr,
  input  logic       byte_fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  localparam int          CNT_W   = $clog2(MAX_DATA_BYTES + 1);
  localparam logic [3:0]  MAX_LEN = 4'(MAX_DATA_BYTES);

  logic [63:0]      resp_mask_r;
  logic [63:0]      recv_mask_r;
  logic [3:0]       data_len_r;

  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [5:0]       cur_id_r;
  logic [5:0]       cur_id_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [7:0]       sum_r;
  logic [7:0]       sum_nxt;

  logic [5:0]       rx_id;
  logic [8:0]       sum_wide;
  logic [7:0]       sum_fold;
  logic [CNT_W-1:0] cnt_inc;
  logic [3:0]       eff_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_mask_r <= RESP_MASK_RST;
      recv_mask_r <= RECV_MASK_RST;
      data_len_r  <= DATA_LEN_RST;
    end else if (cfg_wr.we) begin
      case (cfg_wr.index)
        CFG_RESP_MASK: resp_mask_r <= cfg_wr.data;
        CFG_RECV_MASK: recv_mask_r <= cfg_wr.data;
        CFG_DATA_LEN:  data_len_r  <= cfg_wr.data[3:0];
        default: ;
      endcase
    end
  end

  assign rx_id    = rx_byte[5:0];
  assign sum_wide = {1'b0, sum_r} + {1'b0, rx_byte};
  assign sum_fold = sum_wide[7:0] + {7'd0, sum_wide[8]};
  assign cnt_inc  = cnt_r + CNT_W'(1);

  always_comb begin
    if (data_len_r == 4'd0) begin
      eff_len = 4'd1;
    end else if (data_len_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = data_len_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cur_id_nxt = cur_id_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res        = '0;
    res.frame_id = cur_id_r;
    case (phase_r)
      PH_SYNC: begin
        phase_nxt = (rx_byte == SYNC_BYTE) ? PH_PID : PH_IDLE;
      end
      PH_PID: begin
        phase_nxt = PH_IDLE;
        if (pid_ok(rx_byte)) begin
          if (resp_mask_r[rx_id]) begin
            cur_id_nxt   = rx_id;
            phase_nxt    = PH_RESP;
            res_valid    = 1'b1;
            res.kind     = KIND_RESP;
            res.frame_id = rx_id;
            res.last     = 1'b1;
          end else if (recv_mask_r[rx_id]) begin
            cur_id_nxt = rx_id;
            cnt_nxt    = '0;
            sum_nxt    = (rx_id == ID_DIAG_REQ || rx_id == ID_DIAG_RSP) ? 8'd0 : rx_byte;
            phase_nxt  = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        sum_nxt = sum_fold;
        cnt_nxt = cnt_inc;
        if (4'(cnt_inc) >= eff_len) begin
          phase_nxt = PH_CSUM;
        end
        res_valid      = 1'b1;
        res.kind       = KIND_DATA;
        res.data_byte  = rx_byte;
        res.byte_index = 3'(cnt_r);
      end
      PH_CSUM: begin
        phase_nxt             = PH_IDLE;
        res_valid             = 1'b1;
        res.kind              = KIND_END;
        res.computed_checksum = ~sum_r;
        res.received_checksum = rx_byte;
        res.last              = 1'b1;
      end
      PH_RESP: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = (rx_byte == BREAK_BYTE) ? PH_SYNC : PH_IDLE;
      end
    endcase
    if (!byte_fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cur_id_r <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
    end else if (byte_fire) begin
      phase_r  <= phase_nxt;
      cur_id_r <= cur_id_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> 4'(cnt_r) < MAX_LEN)
    else $error("data count beyond frame capacity");

  a_classic_seed: assert property (@(posedge clk) disable iff (!rst_n)
    byte_fire && phase_r == PH_PID && phase_nxt == PH_DATA &&
    (rx_id == ID_DIAG_REQ || rx_id == ID_DIAG_RSP) |=> sum_r == 8'd0)
    else $error("diagnostic frame not seeded with zero");

  a_end_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_END |=> phase_r == PH_IDLE)
    else $error("frame end did not return to idle");
`endif

endmodule

// ----- sv/lin_slave_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// lin_slave_frame_receiver_top
// LIN slave frame receiver: takes one bus byte per word, tracks break, sync
// and protected id, streams data bytes of frames selected by the receive mask
// and reports the enhanced (or classic for ids 0x3C/0x3D) checksum at frame
// end; ids in the response mask report a header word instead. Every byte is
// handled by one state update, so a byte word can be taken every clock while
// in_ready is high. Result words go through a two-entry output buffer (output
// register plus skid register); in_ready drops only while both hold words.
// Config writes take effect in the following cycle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module lin_slave_frame_receiver_top
  import lsfr_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [5:0]  out_frame_id,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_byte_index,
  output logic [7:0]  out_computed_checksum,
  output logic [7:0]  out_received_checksum,
  output logic        out_last
);

  cfg_wr_t cfg_wr;
  logic    in_fire;
  logic    out_fire;
  logic    res_valid;
  res_t    res;

  logic    out_valid_r;
  logic    out_valid_nxt;
  res_t    out_word_r;
  res_t    out_word_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  res_t    skid_word_r;
  res_t    skid_word_nxt;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  lsfr_core #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .byte_fire (in_fire),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_nxt = res_valid;
      out_word_nxt  = res;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = out_word_r.kind;
  assign out_frame_id          = out_word_r.frame_id;
  assign out_data_byte         = out_word_r.data_byte;
  assign out_byte_index        = out_word_r.byte_index;
  assign out_computed_checksum = out_word_r.computed_checksum;
  assign out_received_checksum = out_word_r.received_checksum;
  assign out_last              = out_word_r.last;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_valid_r && !skid_valid_r)
    else $error("skid word not moved to output");

  a_last_by_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_last == (out_kind != KIND_DATA))
    else $error("last flag does not match word kind");

  a_data_no_csum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind == KIND_DATA |->
      out_computed_checksum == 8'd0 && out_received_checksum == 8'd0)
    else $error("checksum fields set on data word");
`endif

endmodule
